@@ rtl/wefv_pkg.sv @@
// Shared types and constants for the wheel encoder velocity unit.
// No dependencies; every other file in rtl/ imports this package.
package wefv_pkg;

  localparam int WHEEL_COUNT_DEF = 4;

  // Field widths
  localparam int WHEEL_W    = 2;
  localparam int COUNT_W    = 32;
  localparam int PERIOD_W   = 20;
  localparam int Q_W        = 40;
  localparam int SCALE_W    = 32;
  localparam int ALPHA_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Shared multiply-accumulate unit
  localparam int MUL_A_W    = 41;
  localparam int MUL_B_W    = 18;
  localparam int ACC_W      = 65;
  localparam int SCALE_HALF = SCALE_W / 2;

  // Divider: dividend bits and radix-4 step count
  localparam int DIV_W     = 62;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  // one million = 15625 << 6
  localparam logic [MUL_B_W-1:0] USEC_ODD   = MUL_B_W'(15625);
  localparam int                 USEC_SHIFT = 6;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = SCALE_W'(25736);
  localparam logic [ALPHA_W-1:0] POS_ALPHA_RST   = ALPHA_W'(19661);
  localparam logic [ALPHA_W-1:0] VEL_ALPHA_RST   = ALPHA_W'(13107);
  localparam logic               FILTER_EN_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_SCALE    = 2'd0,
    REG_POSITION_ALPHA = 2'd1,
    REG_VELOCITY_ALPHA = 2'd2,
    REG_FILTER_ENABLE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SHADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t                   op;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/wefv_mac.sv @@
// Shared signed multiply-accumulate unit: one 41x18 multiplier and an accumulator.
// Depends on wefv_pkg.
module wefv_mac (
  input  logic                               clk,
  input  wefv_pkg::mac_ctl_t                 ctl,
  output logic signed [wefv_pkg::ACC_W-1:0]  acc
);
  import wefv_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_nxt;

  assign prod     = $signed(ctl.a) * $signed(ctl.b);
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (ctl.op)
      MAC_HOLD:  acc_nxt = acc_r;
      MAC_LOAD:  acc_nxt = prod_ext;
      MAC_ADD:   acc_nxt = acc_r + prod_ext;
      MAC_SHADD: acc_nxt = (acc_r <<< SCALE_HALF) + prod_ext;
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ rtl/wefv_divider.sv @@
// Radix-4 restoring divider, two quotient bits per cycle, 62-bit dividend.
// Depends on wefv_pkg.
module wefv_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wefv_pkg::DIV_W-1:0]    dividend,
  input  logic [wefv_pkg::PERIOD_W-1:0] divisor,
  output logic [wefv_pkg::DIV_W-1:0]    quotient,
  output wefv_pkg::div_stat_t           stat
);
  import wefv_pkg::*;

  logic [DIV_W-1:0]     work_r, work_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PERIOD_W:0]    trial1, trial2;
  logic [PERIOD_W-1:0]  rem_mid;
  logic                 q1, q2;

  always_comb begin
    trial1  = {rem_r, work_r[DIV_W-1]};
    q1      = trial1 >= {1'b0, dsr_r};
    rem_mid = q1 ? PERIOD_W'(trial1 - {1'b0, dsr_r}) : trial1[PERIOD_W-1:0];
    trial2  = {rem_mid, work_r[DIV_W-2]};
    q2      = trial2 >= {1'b0, dsr_r};

    work_nxt = work_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift two dividend bits in, two quotient bits out
      work_nxt = {work_r[DIV_W-3:0], q1, q2};
      rem_nxt  = q2 ? PERIOD_W'(trial2 - {1'b0, dsr_r}) : trial2[PERIOD_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign quotient  = work_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a running division");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((cnt_r != '0) && (cnt_r <= DIV_CNT_W'(DIV_STEPS))))
    else $error("divider step count out of range");

endmodule

@@ rtl/wheel_encoder_filtered_velocity_unit.sv @@
// Top level of the wheel encoder velocity unit: sequencer, per-wheel state,
// configuration registers and output register. Depends on wefv_pkg, wefv_mac, wefv_divider.
//
//   channel  direction  handshake           word
//   in_      sink       in_valid/in_stall   wheel_index, encoder_count, period_us
//   out_     source     out_valid/out_stall wheel_number, position, velocity
//   cfg_     sink       cfg_wr_en           cfg_index, cfg_data (no read-back)
//
// A word takes longest with filtering on and a nonzero period; filtering off skips
// the averaging, a zero period skips the division and a wheel index out of range
// skips all arithmetic. The 31 radix-4 steps of the divider dominate; all products
// go through the single shared multiply-accumulate unit, one product per cycle.
// Reset is synchronous and active low; it restores register defaults and clears
// the per-wheel state. A stalled result sits in the output register while the
// next word is already accepted and processed.
module wheel_encoder_filtered_velocity_unit #(
  parameter int WHEEL_COUNT = wefv_pkg::WHEEL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wefv_pkg::WHEEL_W-1:0]        in_wheel_index,
  input  logic signed [wefv_pkg::COUNT_W-1:0] in_encoder_count,
  input  logic [wefv_pkg::PERIOD_W-1:0]       in_period_us,
  // result word
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wefv_pkg::WHEEL_W-1:0]        out_wheel_number,
  output logic signed [wefv_pkg::Q_W-1:0]     out_position,
  output logic signed [wefv_pkg::Q_W-1:0]     out_velocity,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [wefv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wefv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wefv_pkg::*;

  localparam int IDX_W       = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int ANG_SUM_W   = 2 * COUNT_W;
  localparam int ANG_SHIFT   = 8;
  localparam int ANG_MAG_W   = ANG_SUM_W - ANG_SHIFT;
  localparam int SMOOTH_SH   = 16;

  localparam logic signed [ACC_W-1:0] ACC_QMAX = ACC_W'(Q_MAX);
  localparam logic signed [ACC_W-1:0] ACC_QMIN = ACC_W'(Q_MIN);
  localparam logic signed [ACC_W-1:0] RND_POS  = ACC_W'(1 << (SMOOTH_SH - 1));
  localparam logic signed [ACC_W-1:0] RND_NEG  = ACC_W'((1 << (SMOOTH_SH - 1)) - 1);
  localparam logic [DIV_W-1:0] MAG_POS_LIM = {{(DIV_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] MAG_NEG_LIM = {{(DIV_W-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE,
    S_ANG_HI,
    S_ANG_LO,
    S_ANG_RND,
    S_ANG_SAT,
    S_PS_A,
    S_PS_B,
    S_PS_RND,
    S_DIFF,
    S_VMUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_VSAT,
    S_VS_A,
    S_VS_B,
    S_VS_RND,
    S_COMMIT
  } state_t;

  // saturate a signed accumulator value to Q23.16
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > ACC_QMAX) begin
      r = Q_MAX;
    end else if (v < ACC_QMIN) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // apply sign to a magnitude and saturate to Q23.16
  function automatic logic signed [Q_W-1:0] sat_mag(input logic neg,
                                                     input logic [DIV_W-1:0] m);
    logic signed [Q_W-1:0] r;
    if (neg) begin
      r = (m > MAG_NEG_LIM) ? Q_MIN : -m[Q_W-1:0];
    end else begin
      r = (m > MAG_POS_LIM) ? Q_MAX : m[Q_W-1:0];
    end
    return r;
  endfunction

  state_t                state_r, state_nxt;

  // configuration
  logic [SCALE_W-1:0]    angle_scale_r;
  logic [ALPHA_W-1:0]    position_alpha_r;
  logic [ALPHA_W-1:0]    velocity_alpha_r;
  logic                  filter_enable_r;

  // per-wheel state
  logic signed [Q_W-1:0] rp_r [WHEEL_COUNT];
  logic signed [Q_W-1:0] sp_r [WHEEL_COUNT];
  logic signed [Q_W-1:0] sv_r [WHEEL_COUNT];
  logic signed [Q_W-1:0] rv_r [WHEEL_COUNT];

  // working registers of the current word
  logic [WHEEL_W-1:0]    wheel_r, wheel_nxt;
  logic                  bad_r, bad_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_W-1:0]    mag_r, mag_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [ANG_MAG_W-1:0]  ang_mag_r, ang_mag_nxt;
  logic signed [Q_W-1:0] pos_r, pos_nxt;
  logic signed [Q_W-1:0] vel_r, vel_nxt;
  logic                  dneg_r, dneg_nxt;
  logic [Q_W-1:0]        dmag_r, dmag_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [WHEEL_W-1:0]    out_wheel_r, out_wheel_nxt;
  logic signed [Q_W-1:0] out_pos_r, out_pos_nxt;
  logic signed [Q_W-1:0] out_vel_r, out_vel_nxt;
  logic                  store_en;

  // datapath glue
  logic [IDX_W-1:0]        widx;
  logic signed [Q_W-1:0]   rp_cur, sp_cur, sv_cur, rv_cur;
  logic [ALPHA_W-1:0]      pa, va;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0] rnd_q;
  logic [ANG_SUM_W-1:0]    ang_sum;
  logic signed [Q_W:0]     dif_up, dif_dn;
  logic                    d_lt;
  mac_ctl_t                mac_ctl;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_W-1:0]        quotient;
  div_stat_t               div_stat;

  wefv_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  wefv_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (period_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign widx   = IDX_W'(wheel_r);
  assign rp_cur = rp_r[widx];
  assign sp_cur = sp_r[widx];
  assign sv_cur = sv_r[widx];
  assign rv_cur = rv_r[widx];

  // weights above one mean no smoothing
  assign pa = (position_alpha_r > ALPHA_ONE) ? ALPHA_ONE : position_alpha_r;
  assign va = (velocity_alpha_r > ALPHA_ONE) ? ALPHA_ONE : velocity_alpha_r;

  // round to nearest, ties away from zero, then drop 16 fraction bits
  assign rnd_sum = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
  assign rnd_q   = rnd_sum >>> SMOOTH_SH;

  // angle product is never negative here
  assign ang_sum = acc[ANG_SUM_W-1:0] + ANG_SUM_W'(1 << (ANG_SHIFT - 1));

  assign dif_up = (Q_W+1)'(rp_cur) - (Q_W+1)'(pos_r);
  assign dif_dn = (Q_W+1)'(pos_r) - (Q_W+1)'(rp_cur);
  assign d_lt   = pos_r < rp_cur;

  assign div_dividend = {acc[DIV_W-USEC_SHIFT-1:0], {USEC_SHIFT{1'b0}}}
                      + DIV_W'(period_r >> 1);

  always_comb begin
    state_nxt     = state_r;
    wheel_nxt     = wheel_r;
    bad_nxt       = bad_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    period_nxt    = period_r;
    ang_mag_nxt   = ang_mag_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    // drop the result once taken
    out_valid_nxt = out_valid_r && out_stall;
    out_wheel_nxt = out_wheel_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;
    store_en      = 1'b0;
    div_start     = 1'b0;
    mac_ctl.op    = MAC_HOLD;
    mac_ctl.a     = '0;
    mac_ctl.b     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wheel_nxt  = in_wheel_index;
          bad_nxt    = int'(in_wheel_index) >= WHEEL_COUNT;
          neg_nxt    = in_encoder_count[COUNT_W-1];
          mag_nxt    = in_encoder_count[COUNT_W-1] ? COUNT_W'(-in_encoder_count)
                                                   : in_encoder_count;
          period_nxt = in_period_us;
          state_nxt  = (int'(in_wheel_index) >= WHEEL_COUNT) ? S_COMMIT : S_ANG_HI;
        end
      end
      // count magnitude times scale, upper half of the scale first
      S_ANG_HI: begin
        mac_ctl.op = MAC_LOAD;
        mac_ctl.a  = {{(MUL_A_W-COUNT_W){1'b0}}, mag_r};
        mac_ctl.b  = {2'b00, angle_scale_r[SCALE_W-1:SCALE_HALF]};
        state_nxt  = S_ANG_LO;
      end
      S_ANG_LO: begin
        mac_ctl.op = MAC_SHADD;
        mac_ctl.a  = {{(MUL_A_W-COUNT_W){1'b0}}, mag_r};
        mac_ctl.b  = {2'b00, angle_scale_r[SCALE_HALF-1:0]};
        state_nxt  = S_ANG_RND;
      end
      S_ANG_RND: begin
        ang_mag_nxt = ang_sum[ANG_SUM_W-1:ANG_SHIFT];
        state_nxt   = S_ANG_SAT;
      end
      S_ANG_SAT: begin
        pos_nxt = sat_mag(neg_r, DIV_W'(ang_mag_r));
        if (filter_enable_r) begin
          state_nxt = S_PS_A;
        end else begin
          state_nxt = (period_r != '0) ? S_DIFF : S_COMMIT;
        end
      end
      // position average: a*angle + (1-a)*old
      S_PS_A: begin
        mac_ctl.op = MAC_LOAD;
        mac_ctl.a  = MUL_A_W'(pos_r);
        mac_ctl.b  = {1'b0, pa};
        state_nxt  = S_PS_B;
      end
      S_PS_B: begin
        mac_ctl.op = MAC_ADD;
        mac_ctl.a  = MUL_A_W'(sp_cur);
        mac_ctl.b  = {1'b0, ALPHA_ONE - pa};
        state_nxt  = S_PS_RND;
      end
      S_PS_RND: begin
        pos_nxt   = sat_q(rnd_q);
        state_nxt = (period_r != '0) ? S_DIFF : S_COMMIT;
      end
      // sign and magnitude of the position change
      S_DIFF: begin
        dneg_nxt  = d_lt;
        dmag_nxt  = d_lt ? dif_up[Q_W-1:0] : dif_dn[Q_W-1:0];
        state_nxt = S_VMUL;
      end
      S_VMUL: begin
        mac_ctl.op = MAC_LOAD;
        mac_ctl.a  = {1'b0, dmag_r};
        mac_ctl.b  = USEC_ODD;
        state_nxt  = S_DIV_START;
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_VSAT;
        end
      end
      S_VSAT: begin
        vel_nxt   = sat_mag(dneg_r, quotient);
        state_nxt = filter_enable_r ? S_VS_A : S_COMMIT;
      end
      // velocity average
      S_VS_A: begin
        mac_ctl.op = MAC_LOAD;
        mac_ctl.a  = MUL_A_W'(vel_r);
        mac_ctl.b  = {1'b0, va};
        state_nxt  = S_VS_B;
      end
      S_VS_B: begin
        mac_ctl.op = MAC_ADD;
        mac_ctl.a  = MUL_A_W'(sv_cur);
        mac_ctl.b  = {1'b0, ALPHA_ONE - va};
        state_nxt  = S_VS_RND;
      end
      S_VS_RND: begin
        vel_nxt   = sat_q(rnd_q);
        state_nxt = S_COMMIT;
      end
      // hold until the output register is free, then report, storing state for a valid wheel
      S_COMMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_wheel_nxt = wheel_r;
          if (bad_r) begin
            out_pos_nxt = '0;
            out_vel_nxt = '0;
          end else begin
            store_en    = 1'b1;
            out_pos_nxt = pos_r;
            out_vel_nxt = (period_r != '0) ? vel_r : rv_cur;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      angle_scale_r    <= ANGLE_SCALE_RST;
      position_alpha_r <= POS_ALPHA_RST;
      velocity_alpha_r <= VEL_ALPHA_RST;
      filter_enable_r  <= FILTER_EN_RST;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        rp_r[i] <= '0;
        sp_r[i] <= '0;
        sv_r[i] <= '0;
        rv_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ANGLE_SCALE:    angle_scale_r    <= cfg_data[SCALE_W-1:0];
          REG_POSITION_ALPHA: position_alpha_r <= cfg_data[ALPHA_W-1:0];
          REG_VELOCITY_ALPHA: velocity_alpha_r <= cfg_data[ALPHA_W-1:0];
          REG_FILTER_ENABLE:  filter_enable_r  <= cfg_data[0];
          default:            filter_enable_r  <= filter_enable_r;
        endcase
      end
      if (store_en) begin
        rp_r[widx] <= pos_r;
        if (filter_enable_r) begin
          sp_r[widx] <= pos_r;
        end
        if (period_r != '0) begin
          rv_r[widx] <= vel_r;
          if (filter_enable_r) begin
            sv_r[widx] <= vel_r;
          end
        end
      end
    end
    wheel_r     <= wheel_nxt;
    bad_r       <= bad_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    period_r    <= period_nxt;
    ang_mag_r   <= ang_mag_nxt;
    pos_r       <= pos_nxt;
    vel_r       <= vel_nxt;
    dneg_r      <= dneg_nxt;
    dmag_r      <= dmag_nxt;
    out_wheel_r <= out_wheel_nxt;
    out_pos_r   <= out_pos_nxt;
    out_vel_r   <= out_vel_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_wheel_number = out_wheel_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result word appeared outside commit");

  a_velocity_needs_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VSAT) |-> (period_r != '0))
    else $error("velocity computed for a zero period");

  a_wait_has_division: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on a divider that is not running");

endmodule
